// ===== rtl/crf_pkg.sv =====
// Shared types and constants of the capture record framer.
package crf_pkg;

	localparam logic [7:0] MAGIC_FIRST    = 8'hA7;
	localparam logic [7:0] MAGIC_SECOND   = 8'h5A;
	localparam logic [7:0] RECORD_VERSION = 8'h01;
	localparam logic [8:0] MAX_PAYLOAD    = 9'd256;
	localparam logic [4:0] CHANNEL_RESET  = 5'd15;

	// Input operation codes; a queued command keeps the same encoding as its kind.
	localparam logic OP_START = 1'b0;
	localparam logic OP_DATA  = 1'b1;

	// Command queue geometry; the depth must be a power of two.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	typedef struct packed {
		logic        op;
		logic [7:0]  payload_byte;
		logic [8:0]  frame_length;
		logic [7:0]  rssi;
		logic [7:0]  lqi;
		logic [31:0] timestamp;
	} crf_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       end_of_record;
	} crf_out_t;

	typedef struct packed {
		logic        kind;
		logic        last;
		logic [7:0]  data;
		logic [8:0]  length;
		logic [7:0]  rssi;
		logic [7:0]  lqi;
		logic [31:0] timestamp;
	} crf_cmd_t;

	typedef struct packed {
		logic       record_open;
		logic [8:0] bytes_left;
	} crf_front_stat_t;

	typedef enum logic [3:0] {
		ST_MAGIC0,
		ST_MAGIC1,
		ST_VERSION,
		ST_CHANNEL,
		ST_RSSI,
		ST_LQI,
		ST_TS0,
		ST_TS1,
		ST_TS2,
		ST_TS3,
		ST_LEN0,
		ST_LEN1,
		ST_CHECK
	} step_t;

endpackage

// ===== rtl/crf_queue.sv =====
// Small command queue between the framer front and back ends.
module crf_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  crf_pkg::crf_cmd_t wdata,
	input  logic             pop,
	output crf_pkg::crf_cmd_t rdata,
	output logic             full,
	output logic             empty
);
	import crf_pkg::*;

	crf_cmd_t            entry_q [QDEPTH];
	logic [QPTR_W-1:0]   wptr_q;
	logic [QPTR_W-1:0]   rptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full  = (count_q == QCNT_W'(QDEPTH));
	assign empty = (count_q == '0);
	assign rdata = entry_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= wdata;
		end
	end

endmodule

// ===== rtl/crf_front.sv =====
// Front end: accepts input items, tracks the open record and queues commands.
module crf_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  crf_pkg::crf_in_t        in_data,
	input  logic                    q_full,
	output logic                    q_push,
	output crf_pkg::crf_cmd_t       q_wdata,
	output crf_pkg::crf_front_stat_t stat
);
	import crf_pkg::*;

	logic       record_open_q;
	logic [8:0] bytes_left_q;
	logic       accept;
	logic [8:0] sat_len;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign sat_len  = (in_data.frame_length > MAX_PAYLOAD) ? MAX_PAYLOAD : in_data.frame_length;

	// Stray payload bytes are accepted but never reach the queue.
	assign q_push = accept && ((in_data.op == OP_START) || record_open_q);

	always_comb begin
		q_wdata.kind      = in_data.op;
		q_wdata.last      = (bytes_left_q == 9'd1);
		q_wdata.data      = in_data.payload_byte;
		q_wdata.length    = sat_len;
		q_wdata.rssi      = in_data.rssi;
		q_wdata.lqi       = in_data.lqi;
		q_wdata.timestamp = in_data.timestamp;
	end

	assign stat.record_open = record_open_q;
	assign stat.bytes_left  = bytes_left_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_open_q <= 1'b0;
			bytes_left_q  <= '0;
		end else if (accept) begin
			if (in_data.op == OP_START) begin
				record_open_q <= (sat_len != '0);
				bytes_left_q  <= sat_len;
			end else if (record_open_q) begin
				record_open_q <= (bytes_left_q != 9'd1);
				bytes_left_q  <= bytes_left_q - 9'd1;
			end
		end
	end

endmodule

// ===== rtl/crf_back.sv =====
// Back end: expands queued commands into record bytes and keeps the checksum.
module crf_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [4:0]        channel,
	input  logic              q_empty,
	input  crf_pkg::crf_cmd_t q_rdata,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output crf_pkg::crf_out_t out_data
);
	import crf_pkg::*;

	crf_cmd_t   cur_q;
	logic       cur_valid_q;
	step_t      step_q;
	logic [7:0] sum_q;
	logic       out_valid_q;
	crf_out_t   out_q;

	logic       advance;
	logic       finish;
	step_t      next_step;
	logic [7:0] cur_byte;
	logic       cur_eor;

	assign advance = cur_valid_q && (!out_valid_q || !out_stall);

	always_comb begin
		cur_eor  = 1'b0;
		cur_byte = 8'h00;
		case (step_q)
			ST_MAGIC0:  cur_byte = (cur_q.kind == OP_DATA) ? cur_q.data : MAGIC_FIRST;
			ST_MAGIC1:  cur_byte = MAGIC_SECOND;
			ST_VERSION: cur_byte = RECORD_VERSION;
			ST_CHANNEL: cur_byte = {3'b000, channel};
			ST_RSSI:    cur_byte = cur_q.rssi;
			ST_LQI:     cur_byte = cur_q.lqi;
			ST_TS0:     cur_byte = cur_q.timestamp[7:0];
			ST_TS1:     cur_byte = cur_q.timestamp[15:8];
			ST_TS2:     cur_byte = cur_q.timestamp[23:16];
			ST_TS3:     cur_byte = cur_q.timestamp[31:24];
			ST_LEN0:    cur_byte = cur_q.length[7:0];
			ST_LEN1:    cur_byte = {7'b0000000, cur_q.length[8]};
			ST_CHECK: begin
				cur_byte = sum_q;
				cur_eor  = 1'b1;
			end
			default:    cur_byte = 8'h00;
		endcase
	end

	// A payload command is one byte, plus the checksum when it closes the record.
	// A start command runs through the header, plus the checksum for an empty record.
	always_comb begin
		finish    = 1'b0;
		next_step = step_t'(step_q + 4'd1);
		if (step_q == ST_CHECK) begin
			finish = 1'b1;
		end else if (cur_q.kind == OP_DATA) begin
			finish    = !cur_q.last;
			next_step = ST_CHECK;
		end else if (step_q == ST_LEN1) begin
			finish = (cur_q.length != '0);
		end
	end

	assign q_pop = !q_empty && (!cur_valid_q || (advance && finish));

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			step_q      <= ST_MAGIC0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				cur_valid_q <= 1'b1;
				step_q      <= ST_MAGIC0;
			end else if (advance) begin
				if (finish) begin
					cur_valid_q <= 1'b0;
				end
				step_q <= next_step;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_rdata;
		end
		if (advance) begin
			out_q.out_byte      <= cur_byte;
			out_q.end_of_record <= cur_eor;
			// The magic bytes and the checksum itself stay out of the sum.
			if (cur_q.kind == OP_START && step_q == ST_MAGIC0) begin
				sum_q <= 8'h00;
			end else if (!(cur_q.kind == OP_START && step_q == ST_MAGIC1) &&
					step_q != ST_CHECK) begin
				sum_q <= sum_q + cur_byte;
			end
		end
	end

endmodule

// ===== rtl/capture_record_framer.sv =====
// Top level of the capture record framer.
// The framer takes one input item per cycle as long as its four-entry command queue has room.
// A start item becomes a 12-byte header (13 bytes with the checksum when the length is zero),
// and a payload item becomes one byte, or two when it is the last one and the checksum follows.
// The output side sends one byte per cycle while out_stall is low, so the sustained input rate
// is one item per output byte it produces: a steady payload stream runs at one item per cycle,
// and each start or record end costs the extra output cycles it adds. Payload bytes with no
// open record are taken and dropped. The channel register is written through the cfg port,
// which is always ready, and should be changed only while the framer is idle.
module capture_record_framer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  crf_pkg::crf_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output crf_pkg::crf_out_t out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [4:0]        cfg_data
);
	import crf_pkg::*;

	logic            [4:0] channel_q;
	logic                  q_push;
	logic                  q_pop;
	logic                  q_full;
	logic                  q_empty;
	crf_cmd_t              q_wdata;
	crf_cmd_t              q_rdata;
	crf_front_stat_t       front_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_q <= CHANNEL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			channel_q <= cfg_data;
		end
	end

	crf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_wdata  (q_wdata),
		.stat     (front_stat)
	);

	crf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	crf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.channel   (channel_q),
		.q_empty   (q_empty),
		.q_rdata   (q_rdata),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

`ifndef SYNTHESIS
	a_no_push_when_full : assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command queue written while full");

	a_no_pop_when_empty : assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command queue read while empty");

	a_open_matches_count : assert property (@(posedge clk) disable iff (!arst_n)
		front_stat.record_open == (front_stat.bytes_left != '0))
		else $error("open record flag disagrees with remaining byte count");

	a_push_follows_accept : assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (in_valid && !in_stall))
		else $error("command queued without an accepted transaction");
`endif

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench of the capture record framer: random traffic, stalls and channel settings.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import crf_pkg::*;

	localparam int CYCLE_LIMIT  = 2000000;
	localparam int DRAIN_CYCLES = 40;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	crf_in_t    in_data   = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	crf_out_t   out_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [4:0] cfg_data  = '0;

	capture_record_framer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// Framing state as the testbench sees it.
	logic [4:0] ch_setting   = CHANNEL_RESET;
	logic [8:0] payload_left = '0;
	logic [7:0] csum         = '0;
	logic       rec_open     = 1'b0;

	crf_in_t  stim_q[$];
	crf_out_t expected_bytes[$];

	int pushed_items   = 0;
	int accepted_items = 0;
	int counted_items  = 0;
	int bytes_checked  = 0;
	int records_closed = 0;
	int fail_count     = 0;
	int settings_used  = 1;
	int long_holds     = 0;
	int cycle_count    = 0;

	function automatic void push_plain(input logic [7:0] b, input logic last);
		crf_out_t r;
		r.out_byte      = b;
		r.end_of_record = last;
		expected_bytes.push_back(r);
	endfunction

	function automatic void push_summed(input logic [7:0] b);
		csum = csum + b;
		push_plain(b, 1'b0);
	endfunction

	// Works out the record bytes that one accepted transaction produces.
	function automatic void predict_framing(input crf_in_t it);
		logic [8:0] len;
		if (it.op == OP_START) begin
			len  = (it.frame_length > MAX_PAYLOAD) ? MAX_PAYLOAD : it.frame_length;
			csum = 8'h00;
			push_plain(MAGIC_FIRST, 1'b0);
			push_plain(MAGIC_SECOND, 1'b0);
			push_summed(RECORD_VERSION);
			push_summed({3'b000, ch_setting});
			push_summed(it.rssi);
			push_summed(it.lqi);
			push_summed(it.timestamp[7:0]);
			push_summed(it.timestamp[15:8]);
			push_summed(it.timestamp[23:16]);
			push_summed(it.timestamp[31:24]);
			push_summed(len[7:0]);
			push_summed({7'b0000000, len[8]});
			payload_left = len;
			rec_open     = (len != 9'd0);
			if (len == 9'd0) begin
				push_plain(csum, 1'b1);
			end
		end else if (rec_open) begin
			push_summed(it.payload_byte);
			payload_left = payload_left - 9'd1;
			if (payload_left == 9'd0) begin
				push_plain(csum, 1'b1);
				rec_open = 1'b0;
			end
		end
	endfunction

	// Gap lengths: calm stretches have none, otherwise mostly short ones and a few long.
	function automatic int pick_gap(input logic calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	int   in_gap       = 0;
	int   in_seg_left  = 0;
	logic in_calm      = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_framing(in_data);
				accepted_items++;
			end
			if (!in_valid || !in_stall) begin
				if (in_seg_left == 0) begin
					in_seg_left = $urandom_range(10, 60);
					in_calm     = ($urandom_range(0, 2) == 0);
				end else begin
					in_seg_left--;
				end
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (stim_q.size() > 0) begin
					in_data  <= stim_q.pop_front();
					in_valid <= 1'b1;
					in_gap   = pick_gap(in_calm);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	int   stall_gap     = 0;
	int   hold_left     = 0;
	logic hold_done     = 1'b0;
	int   out_seg_left  = 0;
	logic out_calm      = 1'b0;

	// The first long hold comes early, while the sender still has plenty queued.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_seg_left == 0) begin
				out_seg_left = $urandom_range(10, 60);
				out_calm     = ($urandom_range(0, 2) == 0);
			end else begin
				out_seg_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if ((!hold_done && bytes_checked >= 14) || $urandom_range(0, 999) == 0) begin
				hold_done = 1'b1;
				hold_left = $urandom_range(80, 160);
				long_holds++;
				out_stall <= 1'b1;
			end else if (stall_gap > 0) begin
				stall_gap--;
				out_stall <= 1'b1;
			end else begin
				stall_gap = pick_gap(out_calm);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		crf_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_bytes.size() == 0) begin
				$error("unexpected transaction: out_byte 0x%02h end_of_record %0b",
					out_data.out_byte, out_data.end_of_record);
				fail_count++;
			end else begin
				want = expected_bytes.pop_front();
				if (out_data.out_byte !== want.out_byte) begin
					$error("out_byte: expected 0x%02h, actual 0x%02h",
						want.out_byte, out_data.out_byte);
					fail_count++;
				end
				if (out_data.end_of_record !== want.end_of_record) begin
					$error("end_of_record: expected %0b, actual %0b",
						want.end_of_record, out_data.end_of_record);
					fail_count++;
				end
			end
			bytes_checked++;
			if (out_data.end_of_record === 1'b1)
				records_closed++;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	function automatic crf_in_t rand_item();
		crf_in_t it;
		it.op           = 1'($urandom_range(0, 1));
		it.payload_byte = 8'($urandom_range(0, 255));
		it.frame_length = 9'($urandom_range(0, 511));
		it.rssi         = 8'($urandom_range(0, 255));
		it.lqi          = 8'($urandom_range(0, 255));
		it.timestamp    = $urandom;
		return it;
	endfunction

	function automatic crf_in_t make_item(input logic op, input logic [7:0] pb,
		input logic [8:0] len, input logic [7:0] rssi, input logic [7:0] lqi,
		input logic [31:0] ts);
		crf_in_t it;
		it.op           = op;
		it.payload_byte = pb;
		it.frame_length = len;
		it.rssi         = rssi;
		it.lqi          = lqi;
		it.timestamp    = ts;
		return it;
	endfunction

	function automatic void push_stim(input crf_in_t it, input logic counts);
		stim_q.push_back(it);
		pushed_items++;
		if (counts)
			counted_items++;
	endfunction

	// A start transaction followed by random payload bytes; fewer than the length leaves it open.
	function automatic void add_record(input int len, input int sent);
		crf_in_t it;
		it              = rand_item();
		it.op           = OP_START;
		it.frame_length = len[8:0];
		push_stim(it, 1'b1);
		for (int i = 0; i < sent; i++) begin
			it    = rand_item();
			it.op = OP_DATA;
			push_stim(it, 1'b1);
		end
	endfunction

	function automatic void gen_phase(input int budget, input logic with_big);
		int n;
		int r;
		int len;
		int sent;
		crf_in_t it;
		n = 0;
		if (with_big) begin
			len = ($urandom_range(0, 1) == 0) ? 256 : $urandom_range(257, 511);
			add_record(len, 256);
		end
		while (n < budget) begin
			r = $urandom_range(0, 99);
			if (r < 75) begin
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
				add_record(len, len);
				n += len + 1;
			end else if (r < 88) begin
				len  = $urandom_range(2, 12);
				sent = $urandom_range(0, len - 1);
				add_record(len, sent);
				n += sent + 1;
			end else begin
				for (int i = 0; i < $urandom_range(1, 3); i++) begin
					it    = rand_item();
					it.op = OP_DATA;
					push_stim(it, 1'b0);
				end
			end
		end
		// Close the phase with a complete record so the framer ends idle.
		len = $urandom_range(1, 6);
		add_record(len, len);
	endfunction

	task automatic wait_idle();
		while (accepted_items != pushed_items || expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_channel(input logic [4:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		ch_setting = v;
		settings_used++;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty records at both extremes of the metadata, then a stray byte.
		push_stim(make_item(OP_START, 8'h00, 9'd0, 8'h00, 8'h00, 32'h0000_0000), 1'b1);
		push_stim(make_item(OP_START, 8'hFF, 9'd0, 8'hFF, 8'hFF, 32'hFFFF_FFFF), 1'b1);
		push_stim(make_item(OP_DATA, 8'h12, 9'd0, 8'h00, 8'h00, 32'h0), 1'b0);
		push_stim(make_item(OP_START, 8'h00, 9'd1, 8'h80, 8'h7F, 32'h8000_0000), 1'b1);
		push_stim(make_item(OP_DATA, 8'hFF, 9'h1FF, 8'hFF, 8'hFF, 32'hFFFF_FFFF), 1'b1);
		push_stim(make_item(OP_START, 8'h00, 9'd3, 8'h01, 8'hFE, 32'h1234_5678), 1'b1);
		push_stim(make_item(OP_DATA, 8'h00, 9'd0, 8'h00, 8'h00, 32'h0), 1'b1);
		push_stim(make_item(OP_DATA, 8'hAA, 9'd0, 8'h00, 8'h00, 32'h0), 1'b1);
		push_stim(make_item(OP_DATA, 8'h55, 9'd0, 8'h00, 8'h00, 32'h0), 1'b1);
		// An oversized length is cut to the maximum, then the record is abandoned by a new start.
		push_stim(make_item(OP_START, 8'h00, 9'h1FF, 8'hC3, 8'h3C, 32'hDEAD_BEEF), 1'b1);
		push_stim(make_item(OP_DATA, 8'h01, 9'd0, 8'h00, 8'h00, 32'h0), 1'b1);
		push_stim(make_item(OP_DATA, 8'h80, 9'd0, 8'h00, 8'h00, 32'h0), 1'b1);
		push_stim(make_item(OP_START, 8'h00, 9'd2, 8'h7F, 8'h80, 32'h0000_00FF), 1'b1);
		push_stim(make_item(OP_DATA, 8'hFE, 9'd0, 8'h00, 8'h00, 32'h0), 1'b1);
		push_stim(make_item(OP_DATA, 8'hFF, 9'd0, 8'h00, 8'h00, 32'h0), 1'b1);
		push_stim(make_item(OP_DATA, 8'h77, 9'd0, 8'h00, 8'h00, 32'h0), 1'b0);
		wait_idle();

		write_channel(5'd11);
		gen_phase(40, 1'b0);
		wait_idle();
		write_channel(5'd26);
		gen_phase(30, 1'b1);
		wait_idle();
		write_channel(5'd0);
		gen_phase(40, 1'b0);
		wait_idle();
		write_channel(5'd31);
		gen_phase(30, 1'b0);
		wait_idle();
		write_channel(5'($urandom_range(0, 31)));
		gen_phase(10, 1'b0);
		wait_idle();

		if (expected_bytes.size() != 0) begin
			$error("%0d expected bytes never arrived", expected_bytes.size());
			fail_count++;
		end
		$display("Sent %0d transactions (%0d counted), checked %0d bytes in %0d closed records,",
			accepted_items, counted_items, bytes_checked, records_closed);
		$display("across %0d channel settings with %0d long receiver holds.",
			settings_used, long_holds);
		if (fail_count == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
